// ===== rtl/eqx_pkg.sv =====
// Package for the Euler-to-quaternion block: widths, Q30 constants and
// small rounding helpers shared by the lane and merge modules. No dependencies.
`timescale 1ns / 1ps
package eqx_pkg;
   localparam int AngleWidth  = 16;
   localparam int OutFracBits = 14;
   localparam int OutWidth    = OutFracBits + 2;
   localparam int SeriesTerms = 7;
   localparam int Stages      = 2 + 2 * SeriesTerms;

   localparam logic [33:0] HalfPiQ30    = 34'd1686629713;
   localparam logic [33:0] QuarterPiQ30 = 34'd843314857;
   localparam logic [31:0] OneQ30       = 32'd1073741824;

   // Factorial steps of the series, indexed by term. Each division is done by
   // a reciprocal multiply that is exact for numerators below 2^30; the shift
   // is 30 plus the base-2 logarithm of the divisor, rounded up.
   localparam logic [SeriesTerms:1][31:0] SinDiv = {
      32'd210, 32'd156, 32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
   localparam logic [SeriesTerms:1][31:0] CosDiv = {
      32'd182, 32'd132, 32'd90, 32'd56, 32'd30, 32'd12, 32'd2};
   localparam logic [SeriesTerms:1][5:0] SinShift = {
      6'd38, 6'd38, 6'd37, 6'd37, 6'd36, 6'd35, 6'd33};
   localparam logic [SeriesTerms:1][5:0] CosShift = {
      6'd38, 6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31};
   localparam logic [SeriesTerms:1][31:0] SinRecip = {
      32'((64'd1 << 38) / 64'd210 + 64'd1), 32'((64'd1 << 38) / 64'd156 + 64'd1),
      32'((64'd1 << 37) / 64'd110 + 64'd1), 32'((64'd1 << 37) / 64'd72 + 64'd1),
      32'((64'd1 << 36) / 64'd42 + 64'd1),  32'((64'd1 << 35) / 64'd20 + 64'd1),
      32'((64'd1 << 33) / 64'd6 + 64'd1)};
   localparam logic [SeriesTerms:1][31:0] CosRecip = {
      32'((64'd1 << 38) / 64'd182 + 64'd1), 32'((64'd1 << 38) / 64'd132 + 64'd1),
      32'((64'd1 << 37) / 64'd90 + 64'd1),  32'((64'd1 << 36) / 64'd56 + 64'd1),
      32'((64'd1 << 35) / 64'd30 + 64'd1),  32'((64'd1 << 34) / 64'd12 + 64'd1),
      32'((64'd1 << 31) / 64'd2 + 64'd1)};

   // Sine and cosine of one half angle, signed Q30.
   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] c;
   } sincos_type;

   // Unsigned Q30 product, rounded to nearest.
   function automatic logic [31:0] umul_q30(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b) + 64'(1 << 29);
      return p[61:30];
   endfunction

   // Quotient by a constant through its reciprocal.
   function automatic logic [31:0] div_recip(input logic [31:0] a, input logic [31:0] m,
                                             input logic [5:0] s);
      logic [63:0] p;
      p = 64'(a) * 64'(m);
      return 32'(p >> s);
   endfunction

   // Signed Q30 product, rounded to nearest, ties away from zero.
   function automatic logic signed [31:0] smul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [63:0] p;
      logic [63:0]        m;
      p = 64'(a) * 64'(b);
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + 64'(1 << 29)) >> 30;
      return p[63] ? -32'(m) : 32'(m);
   endfunction
endpackage

// ===== rtl/eqx_if.sv =====
// Valid/ready stream interface used by the request and response channels.
// Depends on nothing; the payload type is set per instance.
`timescale 1ns / 1ps
interface eqx_if #(type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/eqx_lane.sv =====
// One sine/cosine lane: quadrant reduction and a pipelined Taylor series.
// Advances when enable is high. Depends on eqx_pkg.
`timescale 1ns / 1ps
module eqx_lane
   import eqx_pkg::*;
(
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [AngleWidth-1:0] angle,
   output sincos_type                   result
);
   localparam int Last = 2 * SeriesTerms;

   logic [31:0] r2_ff [0:Last];
   logic [31:0] ts_ff [0:Last];
   logic [31:0] tc_ff [0:Last];
   logic signed [33:0] ss_ff [0:Last];
   logic signed [33:0] cs_ff [0:Last];
   logic        neg_ff  [0:Last];
   logic [1:0]  quad_ff [0:Last];
   logic signed [33:0] rred_ff;
   logic [1:0]  quad0_ff;

   logic signed [33:0] r_in;
   logic signed [33:0] rr;
   logic [1:0]         q;
   logic [31:0]        sq_in [1:SeriesTerms];
   logic [31:0]        cq_in [1:SeriesTerms];

   // Stage 0: reduce the Q30 half angle (|r| <= 4) by at most three steps.
   always_comb begin
      r_in = 34'(angle) <<< (33 - AngleWidth);
      rr   = r_in;
      q    = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if (rr > $signed(QuarterPiQ30)) begin
            rr = rr - $signed(HalfPiQ30);
            q  = q + 2'd1;
         end else if (rr < -$signed(QuarterPiQ30)) begin
            rr = rr + $signed(HalfPiQ30);
            q  = q - 2'd1;
         end
      end
   end

   always_comb begin
      for (int n = 1; n <= SeriesTerms; n++) begin
         sq_in[n] = div_recip(ts_ff[2*n-1] + (SinDiv[n] >> 1), SinRecip[n], SinShift[n]);
         cq_in[n] = div_recip(tc_ff[2*n-1] + (CosDiv[n] >> 1), CosRecip[n], CosShift[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rred_ff  <= rr;
         quad0_ff <= q;
         // Stage 1: magnitude and square.
         neg_ff[0]  <= rred_ff[33];
         r2_ff[0]   <= umul_q30(rred_ff[33] ? 32'(-rred_ff) : 32'(rred_ff),
                                rred_ff[33] ? 32'(-rred_ff) : 32'(rred_ff));
         ts_ff[0]   <= rred_ff[33] ? 32'(-rred_ff) : 32'(rred_ff);
         tc_ff[0]   <= OneQ30;
         ss_ff[0]   <= rred_ff[33] ? -rred_ff : rred_ff;
         cs_ff[0]   <= 34'(OneQ30);
         quad_ff[0] <= quad0_ff;
         // Each term takes two stages: a product, then the factorial division.
         for (int n = 1; n <= SeriesTerms; n++) begin
            r2_ff[2*n-1]   <= r2_ff[2*n-2];
            ss_ff[2*n-1]   <= ss_ff[2*n-2];
            cs_ff[2*n-1]   <= cs_ff[2*n-2];
            neg_ff[2*n-1]  <= neg_ff[2*n-2];
            quad_ff[2*n-1] <= quad_ff[2*n-2];
            ts_ff[2*n-1]   <= umul_q30(ts_ff[2*n-2], r2_ff[2*n-2]);
            tc_ff[2*n-1]   <= umul_q30(tc_ff[2*n-2], r2_ff[2*n-2]);

            r2_ff[2*n]   <= r2_ff[2*n-1];
            neg_ff[2*n]  <= neg_ff[2*n-1];
            quad_ff[2*n] <= quad_ff[2*n-1];
            ts_ff[2*n]   <= sq_in[n];
            tc_ff[2*n]   <= cq_in[n];
            if ((n & 1) == 1) begin
               ss_ff[2*n] <= ss_ff[2*n-1] - 34'(sq_in[n]);
               cs_ff[2*n] <= cs_ff[2*n-1] - 34'(cq_in[n]);
            end else begin
               ss_ff[2*n] <= ss_ff[2*n-1] + 34'(sq_in[n]);
               cs_ff[2*n] <= cs_ff[2*n-1] + 34'(cq_in[n]);
            end
         end
      end
   end

   logic signed [31:0] ss_f;
   logic signed [31:0] cs_f;

   always_comb begin
      ss_f = neg_ff[Last] ? -32'(ss_ff[Last]) : 32'(ss_ff[Last]);
      cs_f = 32'(cs_ff[Last]);
      case (quad_ff[Last])
         2'd0: begin result.s = ss_f;  result.c = cs_f;  end
         2'd1: begin result.s = cs_f;  result.c = -ss_f; end
         2'd2: begin result.s = -ss_f; result.c = -cs_f; end
         default: begin result.s = -cs_f; result.c = ss_f; end
      endcase
   end
endmodule

// ===== rtl/eqx_merge.sv =====
// Merge stage: forms the four quaternion components from the lane results
// in three registered steps and rounds to Q1.14. Depends on eqx_pkg.
`timescale 1ns / 1ps
module eqx_merge
   import eqx_pkg::*;
(
   input  logic                       clock,
   input  logic                       enable,
   input  sincos_type                 yaw,
   input  sincos_type                 roll,
   input  sincos_type                 pitch,
   output logic signed [OutWidth-1:0] quat [0:3]
);
   logic signed [31:0] ab_ff [0:7];
   logic signed [31:0] c_ff  [0:7];
   logic signed [63:0] p_ff  [0:7];
   logic signed [64:0] sum_ff [0:3];

   logic signed [31:0] a_in [0:7];
   logic signed [31:0] b_in [0:7];
   logic signed [31:0] c_in [0:7];

   always_comb begin
      a_in[0] = yaw.s; b_in[0] = roll.s; c_in[0] = pitch.c;
      a_in[1] = yaw.c; b_in[1] = roll.c; c_in[1] = pitch.s;
      a_in[2] = yaw.s; b_in[2] = roll.c; c_in[2] = pitch.c;
      a_in[3] = yaw.c; b_in[3] = roll.s; c_in[3] = pitch.s;
      a_in[4] = yaw.c; b_in[4] = roll.s; c_in[4] = pitch.c;
      a_in[5] = yaw.s; b_in[5] = roll.c; c_in[5] = pitch.s;
      a_in[6] = yaw.c; b_in[6] = roll.c; c_in[6] = pitch.c;
      a_in[7] = yaw.s; b_in[7] = roll.s; c_in[7] = pitch.s;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 8; i++) begin
            ab_ff[i] <= smul_q30(a_in[i], b_in[i]);
            c_ff[i]  <= c_in[i];
            p_ff[i]  <= 64'(ab_ff[i]) * 64'(c_ff[i]);
         end
         sum_ff[0] <= 65'(p_ff[0]) + 65'(p_ff[1]);
         sum_ff[1] <= 65'(p_ff[2]) + 65'(p_ff[3]);
         sum_ff[2] <= 65'(p_ff[4]) - 65'(p_ff[5]);
         sum_ff[3] <= 65'(p_ff[6]) - 65'(p_ff[7]);
      end
   end

   localparam int Sh = 60 - OutFracBits;
   localparam logic [64:0] Lim = 65'(1) << OutFracBits;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [64:0] m;
         m = sum_ff[i][64] ? 65'(-sum_ff[i]) : 65'(sum_ff[i]);
         m = (m + (65'(1) << (Sh - 1))) >> Sh;
         if (m > Lim) m = Lim;
         quat[i] = sum_ff[i][64] ? -OutWidth'(m) : OutWidth'(m);
      end
   end
endmodule

// ===== rtl/euler_to_quat_xzy.sv =====
// Converts pitch/yaw/roll (signed Q3.12 radians) into the XZY rotation quaternion
// in signed Q1.14, saturated to +/-1. Fully pipelined: one word is taken per cycle
// and each result passes 19 register stages, set by three sine/cosine lanes of
// 16 stages (reduction, magnitude and square, two per series term) and the 3-stage merge.
// A flow-controlled pipeline stalls as a whole only while a result waits unread.
`timescale 1ns / 1ps
module euler_to_quat_xzy
   import eqx_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [AngleWidth-1:0] req_pitch_angle,
   input  logic signed [AngleWidth-1:0] req_yaw_angle,
   input  logic signed [AngleWidth-1:0] req_roll_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OutWidth-1:0]   rsp_quat_x,
   output logic signed [OutWidth-1:0]   rsp_quat_y,
   output logic signed [OutWidth-1:0]   rsp_quat_z,
   output logic signed [OutWidth-1:0]   rsp_quat_w
);
   localparam int Depth = Stages + 3;

   logic [Depth-1:0] vld_ff;
   logic             enable;
   sincos_type       s_yaw, s_roll, s_pitch;
   logic signed [OutWidth-1:0] quat [0:3];

   // The whole pipe advances unless the final word is valid and not taken.
   assign enable    = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   eqx_lane u_yaw   (.clock, .enable, .angle(req_yaw_angle),   .result(s_yaw));
   eqx_lane u_roll  (.clock, .enable, .angle(req_roll_angle),  .result(s_roll));
   eqx_lane u_pitch (.clock, .enable, .angle(req_pitch_angle), .result(s_pitch));

   eqx_merge u_merge (.clock, .enable, .yaw(s_yaw), .roll(s_roll), .pitch(s_pitch),
                      .quat(quat));

   assign rsp_quat_x = quat[0];
   assign rsp_quat_y = quat[1];
   assign rsp_quat_z = quat[2];
   assign rsp_quat_w = quat[3];
endmodule

// ===== dv/tb_top.sv =====
// Testbench for euler_to_quat_xzy: drives angle triples through a bursty sender,
// checks every quaternion against a bit-exact fixed-point predictor.
// Depends on eqx_pkg and eqx_if from the RTL.
`timescale 1ns / 1ps
module tb_top
   import eqx_pkg::*;
;

   typedef struct packed {
      logic signed [AngleWidth-1:0] pitch;
      logic signed [AngleWidth-1:0] yaw;
      logic signed [AngleWidth-1:0] roll;
   } angles_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] x;
      logic signed [OutWidth-1:0] y;
      logic signed [OutWidth-1:0] z;
      logic signed [OutWidth-1:0] w;
   } quat_type;

   localparam longint HalfPi    = 64'd1686629713;
   localparam longint QuarterPi = 64'd843314857;
   localparam longint One       = 64'd1 << 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   eqx_if #(.payload_type(angles_type)) req_ch ();
   eqx_if #(.payload_type(quat_type))   rsp_ch ();

   angles_type pending_angles[$];
   quat_type   expected_quats[$];
   int      error_count = 0;
   int      accepted_count = 0;

   euler_to_quat_xzy i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_pitch_angle (req_ch.data.pitch),
      .req_yaw_angle   (req_ch.data.yaw),
      .req_roll_angle  (req_ch.data.roll),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_quat_x      (rsp_ch.data.x),
      .rsp_quat_y      (rsp_ch.data.y),
      .rsp_quat_z      (rsp_ch.data.z),
      .rsp_quat_w      (rsp_ch.data.w)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rounds to nearest with ties away from zero.
   function automatic longint round_shift(input longint v, input int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (s - 1))) >>> s;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint urnd_q30(input longint a, input longint b);
      return (a * b + (64'd1 << 29)) >>> 30;
   endfunction

   function automatic longint div_nearest(input longint a, input longint d);
      return (a + d / 2) / d;
   endfunction

   // Sine and cosine of half the angle, Q30.
   task automatic half_sin_cos(input logic signed [AngleWidth-1:0] ang,
                               output longint s, output longint c);
      longint r, rm, r2, ts, tc, ss, cs, k;
      int     quad;
      r = longint'(ang) * (64'd1 << (33 - AngleWidth));
      quad = 0;
      for (int g = 0; g < 8 && r > QuarterPi; g++) begin
         r -= HalfPi;
         quad++;
      end
      for (int g = 0; g < 8 && r < -QuarterPi; g++) begin
         r += HalfPi;
         quad--;
      end
      rm = (r < 0) ? -r : r;
      r2 = urnd_q30(rm, rm);
      ts = rm;
      tc = One;
      ss = rm;
      cs = One;
      for (int n = 1; n <= SeriesTerms; n++) begin
         k = 2 * n;
         ts = div_nearest(urnd_q30(ts, r2), k * (k + 1));
         tc = div_nearest(urnd_q30(tc, r2), (k - 1) * k);
         if (n % 2 == 1) begin
            ss -= ts;
            cs -= tc;
         end else begin
            ss += ts;
            cs += tc;
         end
      end
      if (r < 0) ss = -ss;
      case (quad & 3)
         0: begin s = ss;  c = cs;  end
         1: begin s = cs;  c = -ss; end
         2: begin s = -ss; c = -cs; end
         default: begin s = -cs; c = ss; end
      endcase
   endtask

   function automatic longint triple(input longint a, input longint b, input longint c);
      return round_shift(a * b, 30) * c;
   endfunction

   function automatic logic [OutWidth-1:0] to_q14(input longint q60);
      longint v, lim;
      v = round_shift(q60, 60 - OutFracBits);
      lim = 64'd1 << OutFracBits;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[OutWidth-1:0];
   endfunction

   task automatic predict_quat(input angles_type a, output quat_type q);
      longint s1, c1, s2, c2, s3, c3;
      half_sin_cos(a.yaw, s1, c1);
      half_sin_cos(a.roll, s2, c2);
      half_sin_cos(a.pitch, s3, c3);
      q.x = to_q14(triple(s1, s2, c3) + triple(c1, c2, s3));
      q.y = to_q14(triple(s1, c2, c3) + triple(c1, s2, s3));
      q.z = to_q14(triple(c1, s2, c3) - triple(s1, c2, s3));
      q.w = to_q14(triple(c1, c2, c3) - triple(s1, s2, s3));
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      quat_type q;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_quat(req_ch.data, q);
            expected_quats.push_back(q);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_angles.size() > 0) begin
               req_ch.valid <= 1'b1;
               req_ch.data <= pending_angles.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls on a rotating pattern, with one long hold-off to back up the pipe.
   int     cycle_count = 0;
   int     hold_left = 0;
   logic   held_once = 1'b0;
   always @(posedge clock) begin
      quat_type e;
      cycle_count++;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_quats.size() == 0) begin
               $display("%0t: unexpected word x=%0d y=%0d z=%0d w=%0d", $time,
                        rsp_ch.data.x, rsp_ch.data.y, rsp_ch.data.z, rsp_ch.data.w);
               error_count++;
            end else begin
               e = expected_quats.pop_front();
               if (e.x !== rsp_ch.data.x || e.y !== rsp_ch.data.y ||
                   e.z !== rsp_ch.data.z || e.w !== rsp_ch.data.w) begin
                  $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d, got x=%0d y=%0d z=%0d w=%0d",
                           $time, e.x, e.y, e.z, e.w, rsp_ch.data.x, rsp_ch.data.y,
                           rsp_ch.data.z, rsp_ch.data.w);
                  error_count++;
               end
            end
         end
         if (!held_once && accepted_count >= 400) begin
            held_once <= 1'b1;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((cycle_count / 97) % 3)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               default: rsp_ch.ready <= (cycle_count % 5 != 0);
            endcase
         end
      end
   end

   task automatic add_angles(input int p, input int y, input int r);
      angles_type a;
      a.pitch = p[AngleWidth-1:0];
      a.yaw = y[AngleWidth-1:0];
      a.roll = r[AngleWidth-1:0];
      pending_angles.push_back(a);
   endtask

   function automatic int random_angle();
      // Mostly full range; some stay near zero or near quadrant boundaries.
      case ($urandom_range(0, 5))
         0: return $signed(16'($urandom_range(0, 255))) - 128;
         1: return ($urandom_range(0, 1) ? 6434 : -6434) + $urandom_range(0, 6) - 3;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   initial begin
      // Zero, extremes, quarter-turn boundaries of the half angle and a full half-turn.
      add_angles(0, 0, 0);
      add_angles(32767, 32767, 32767);
      add_angles(-32768, -32768, -32768);
      add_angles(32767, -32768, 0);
      add_angles(-32768, 0, 32767);
      add_angles(0, 32767, -32768);
      add_angles(6433, 6434, 6435);
      add_angles(-6433, -6434, -6435);
      add_angles(12868, 0, 0);
      add_angles(0, 12868, 0);
      add_angles(0, 0, 12868);
      add_angles(25736, -25736, 19302);
      add_angles(1, -1, 1);
      add_angles(-1, 1, -1);
      add_angles(-12868, 6434, -19302);
      add_angles(6434, 6434, 6434);
      for (int i = 0; i < 1434; i++)
         add_angles(random_angle(), random_angle(), random_angle());
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_angles.size() > 0 || req_ch.valid || expected_quats.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_quats.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/eqx_pkg.sv
rtl/eqx_if.sv
rtl/eqx_lane.sv
rtl/eqx_merge.sv
rtl/euler_to_quat_xzy.sv
dv/tb_top.sv
